// ===== hdl/ctc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

    // Mode codes as seen on the result port.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_COOK  = 3'd2;
    localparam logic [2:0] MODE_DOOR  = 3'd3;
    localparam logic [2:0] MODE_PAUSE = 3'd4;
    localparam logic [2:0] MODE_ALERT = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TICKS_PER_SECOND  = 3'd0;
    localparam logic [2:0] CFG_BLINK_TICKS       = 3'd1;
    localparam logic [2:0] CFG_PAUSE_GUARD_TICKS = 3'd2;
    localparam logic [2:0] CFG_ALERT_TOGGLES     = 3'd3;
    localparam logic [2:0] CFG_ALERT_TICKS       = 3'd4;

    localparam logic [6:0] TICK_MAX = 7'd127;

    typedef struct packed {
        logic [6:0] ticks_per_second;
        logic [6:0] blink_ticks;
        logic [6:0] pause_guard_ticks;
        logic [2:0] alert_toggles;
        logic [6:0] alert_ticks;
    } t_cfg;

    typedef struct packed {
        logic       operation;
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
        logic       sw1_pressed;
        logic       sw2_pressed;
        logic       door_closed;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
        logic [6:0] second_ticks;
        logic [6:0] blink_count;
        logic [2:0] toggles_done;
        logic       lamp;
        logic       buzzer;
        logic [6:0] guard_left;
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
        logic       lamp;
        logic       buzzer;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ctc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic for one tick or start beat.
module ctc_step (
    input  wire ctc_pkg::t_state i_state,
    input  wire ctc_pkg::t_cfg   i_cfg,
    input  wire ctc_pkg::t_item  i_item,
    output ctc_pkg::t_state      o_state
);

    logic       sw1;
    logic       sw2;
    logic       door;
    logic [6:0] sec_bump;
    logic [6:0] blink_bump;
    logic       time_zero;

    assign sw1  = i_item.sw1_pressed & ~i_item.sw2_pressed;
    assign sw2  = i_item.sw2_pressed & ~i_item.sw1_pressed;
    assign door = i_item.door_closed;

    assign sec_bump   = (i_state.second_ticks < ctc_pkg::TICK_MAX) ?
                        i_state.second_ticks + 7'd1 : i_state.second_ticks;
    assign blink_bump = (i_state.blink_count < ctc_pkg::TICK_MAX) ?
                        i_state.blink_count + 7'd1 : i_state.blink_count;

    assign time_zero = (i_state.min_tens == 4'd0) && (i_state.min_ones == 4'd0) &&
                       (i_state.sec_tens == 3'd0) && (i_state.sec_ones == 4'd0);

    always_comb begin
        o_state = i_state;
        if (i_item.operation) begin
            o_state.min_tens     = (i_item.min_tens > 4'd9) ? 4'd9 : i_item.min_tens;
            o_state.min_ones     = (i_item.min_ones > 4'd9) ? 4'd9 : i_item.min_ones;
            o_state.sec_tens     = (i_item.sec_tens > 3'd5) ? 3'd5 : i_item.sec_tens;
            o_state.sec_ones     = (i_item.sec_ones > 4'd9) ? 4'd9 : i_item.sec_ones;
            o_state.second_ticks = 7'd0;
            o_state.blink_count  = 7'd0;
            o_state.toggles_done = 3'd0;
            o_state.guard_left   = 7'd0;
            o_state.lamp         = door;
            o_state.mode         = door ? ctc_pkg::MODE_COOK : ctc_pkg::MODE_WAIT;
        end else begin
            case (i_state.mode)
                ctc_pkg::MODE_WAIT: begin
                    if (door) begin
                        o_state.mode         = ctc_pkg::MODE_COOK;
                        o_state.lamp         = 1'b1;
                        o_state.second_ticks = 7'd0;
                    end
                end
                ctc_pkg::MODE_COOK: begin
                    o_state.second_ticks = sec_bump;
                    if (!door) begin
                        o_state.mode        = ctc_pkg::MODE_DOOR;
                        o_state.blink_count = 7'd0;
                    end else if (sw1) begin
                        o_state.mode        = ctc_pkg::MODE_PAUSE;
                        o_state.blink_count = 7'd0;
                        o_state.guard_left  = i_cfg.pause_guard_ticks;
                    end else if (sec_bump >= i_cfg.ticks_per_second) begin
                        o_state.second_ticks = 7'd0;
                        if (time_zero) begin
                            // Time ran out: start the finish alert, or go idle when no alert toggles are set.
                            o_state.blink_count  = 7'd0;
                            o_state.toggles_done = 3'd0;
                            if (i_cfg.alert_toggles == 3'd0) begin
                                o_state.lamp = 1'b0;
                                o_state.mode = ctc_pkg::MODE_IDLE;
                            end else begin
                                o_state.lamp         = ~i_state.lamp;
                                o_state.buzzer       = ~i_state.buzzer;
                                o_state.toggles_done = 3'd1;
                                o_state.mode         = ctc_pkg::MODE_ALERT;
                            end
                        end else if (i_state.sec_ones != 4'd0) begin
                            o_state.sec_ones = i_state.sec_ones - 4'd1;
                        end else begin
                            o_state.sec_ones = 4'd9;
                            if (i_state.sec_tens != 3'd0) begin
                                o_state.sec_tens = i_state.sec_tens - 3'd1;
                            end else begin
                                o_state.sec_tens = 3'd5;
                                if (i_state.min_ones != 4'd0) begin
                                    o_state.min_ones = i_state.min_ones - 4'd1;
                                end else begin
                                    o_state.min_ones = 4'd9;
                                    if (i_state.min_tens != 4'd0) begin
                                        o_state.min_tens = i_state.min_tens - 4'd1;
                                    end
                                end
                            end
                        end
                    end
                end
                ctc_pkg::MODE_DOOR: begin
                    o_state.blink_count = blink_bump;
                    if (door) begin
                        o_state.mode        = ctc_pkg::MODE_COOK;
                        o_state.lamp        = 1'b1;
                        o_state.blink_count = 7'd0;
                    end else if (blink_bump >= i_cfg.blink_ticks) begin
                        o_state.lamp        = ~i_state.lamp;
                        o_state.blink_count = 7'd0;
                    end
                end
                ctc_pkg::MODE_PAUSE: begin
                    if (i_state.guard_left != 7'd0) begin
                        o_state.guard_left = i_state.guard_left - 7'd1;
                    end else begin
                        o_state.blink_count = blink_bump;
                        if (sw1) begin
                            o_state.mode        = ctc_pkg::MODE_IDLE;
                            o_state.lamp        = 1'b0;
                            o_state.blink_count = 7'd0;
                        end else if (sw2) begin
                            o_state.mode        = ctc_pkg::MODE_COOK;
                            o_state.lamp        = 1'b1;
                            o_state.blink_count = 7'd0;
                        end else if (blink_bump >= i_cfg.blink_ticks) begin
                            o_state.lamp        = ~i_state.lamp;
                            o_state.blink_count = 7'd0;
                        end
                    end
                end
                ctc_pkg::MODE_ALERT: begin
                    o_state.blink_count = blink_bump;
                    if (blink_bump >= i_cfg.alert_ticks) begin
                        o_state.blink_count = 7'd0;
                        if (i_state.toggles_done >= i_cfg.alert_toggles) begin
                            o_state.lamp = 1'b0;
                            o_state.mode = ctc_pkg::MODE_IDLE;
                        end else begin
                            o_state.lamp         = ~i_state.lamp;
                            o_state.buzzer       = ~i_state.buzzer;
                            o_state.toggles_done = i_state.toggles_done + 3'd1;
                        end
                    end
                end
                default: begin
                    o_state.mode = ctc_pkg::MODE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cook_timer_controller.sv =====
// Each accepted input beat's result is registered in the output stage.
// One input beat per cycle while the skid entry is empty; controller state updates in one pass.
// A two-entry output stage keeps accepting while one finished result waits.
// Reset (synchronous, active low) sets idle mode, time 00:00, lamp and buzzer off,
// and the configuration registers to their default values.
`timescale 1ns / 1ps
`default_nettype none

module cook_timer_controller (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_idx,
    input  wire  [6:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_operation,
    input  wire  [3:0] i_min_tens,
    input  wire  [3:0] i_min_ones,
    input  wire  [2:0] i_sec_tens,
    input  wire  [3:0] i_sec_ones,
    input  wire        i_sw1_pressed,
    input  wire        i_sw2_pressed,
    input  wire        i_door_closed,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [2:0] o_mode,
    output logic [3:0] o_rem_min_tens,
    output logic [3:0] o_rem_min_ones,
    output logic [2:0] o_rem_sec_tens,
    output logic [3:0] o_rem_sec_ones,
    output logic       o_lamp_on,
    output logic       o_buzzer_on
);

    ctc_pkg::t_cfg    r_cfg;
    ctc_pkg::t_state  r_state;
    ctc_pkg::t_state  n_state;
    ctc_pkg::t_item   item;
    ctc_pkg::t_result new_result;
    ctc_pkg::t_result r_out;
    ctc_pkg::t_result r_skid;
    logic             r_out_vld;
    logic             r_skid_vld;
    logic             accept;
    logic             pop;

    assign item = '{operation:   i_operation,
                    min_tens:    i_min_tens,
                    min_ones:    i_min_ones,
                    sec_tens:    i_sec_tens,
                    sec_ones:    i_sec_ones,
                    sw1_pressed: i_sw1_pressed,
                    sw2_pressed: i_sw2_pressed,
                    door_closed: i_door_closed};

    ctc_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (item),
        .o_state (n_state)
    );

    assign new_result = '{mode:     n_state.mode,
                          min_tens: n_state.min_tens,
                          min_ones: n_state.min_ones,
                          sec_tens: n_state.sec_tens,
                          sec_ones: n_state.sec_ones,
                          lamp:     n_state.lamp,
                          buzzer:   n_state.buzzer};

    assign o_in_ready = ~r_skid_vld;
    assign accept     = i_in_valid & o_in_ready;
    assign pop        = r_out_vld & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second  <= 7'd100;
            r_cfg.blink_ticks       <= 7'd75;
            r_cfg.pause_guard_ticks <= 7'd25;
            r_cfg.alert_toggles     <= 3'd6;
            r_cfg.alert_ticks       <= 7'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctc_pkg::CFG_TICKS_PER_SECOND:  r_cfg.ticks_per_second  <= i_cfg_data;
                ctc_pkg::CFG_BLINK_TICKS:       r_cfg.blink_ticks       <= i_cfg_data;
                ctc_pkg::CFG_PAUSE_GUARD_TICKS: r_cfg.pause_guard_ticks <= i_cfg_data;
                ctc_pkg::CFG_ALERT_TOGGLES:     r_cfg.alert_toggles     <= i_cfg_data[2:0];
                ctc_pkg::CFG_ALERT_TICKS:       r_cfg.alert_ticks       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // The skid entry only fills when the output register is held by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_out_vld && !pop) begin
                if (accept) begin
                    r_skid_vld <= 1'b1;
                end
            end else begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= accept;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !pop) begin
            if (accept) begin
                r_skid <= new_result;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else if (accept) begin
            r_out <= new_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_mode         = r_out.mode;
    assign o_rem_min_tens = r_out.min_tens;
    assign o_rem_min_ones = r_out.min_ones;
    assign o_rem_sec_tens = r_out.sec_tens;
    assign o_rem_sec_ones = r_out.sec_ones;
    assign o_lamp_on      = r_out.lamp;
    assign o_buzzer_on    = r_out.buzzer;

endmodule

`default_nettype wire
